### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. They expand to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/fbacc_pkg.sv
// ----------------------------------------------------------------------------
// fbacc_pkg
// Widths, opcode names and shared types of the four-bit accumulator core.
// ----------------------------------------------------------------------------
package fbacc_pkg;

  localparam int unsigned INSTR_W   = 8;
  localparam int unsigned PC_W      = 8;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned OP_W      = 3;

  // Bit positions inside the instruction byte and the accumulator.
  localparam int unsigned BRANCH_POS = 7;
  localparam int unsigned OP_LSB     = 4;
  localparam int unsigned IMM_SEL    = 2;  // opcode bit that picks the immediate
  localparam int unsigned STORE_POS  = 3;  // load/store direction bit
  localparam int unsigned SIGN_POS   = 3;  // accumulator bit tested by branches

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_NAND    = 3'd1,
    OP_XOR     = 3'd2,
    OP_ILLEGAL = 3'd3,
    OP_ADDI    = 3'd4,
    OP_NANDI   = 3'd5,
    OP_XORI    = 3'd6,
    OP_LDST    = 3'd7
  } op_e;

  // Outcome of executing one instruction against the current state.
  typedef struct packed {
    logic [PC_W-1:0]      next_pc;
    logic [NIB_W-1:0]     acc;
    logic                 reg_we;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [NIB_W-1:0]     reg_data;
    logic                 taken;
    logic                 illegal;
  } exec_t;

  // One result item as it sits in the output register.
  typedef struct packed {
    logic [PC_W-1:0]  next_pc;
    logic [NIB_W-1:0] accumulator;
    logic [NIB_W-1:0] out_port;
    logic             branch_taken;
    logic             illegal;
  } result_t;

endpackage

### design/fbacc_if.sv
// ----------------------------------------------------------------------------
// fbacc channel interfaces
// Valid/ready channels for instruction bytes and for result items.
// ----------------------------------------------------------------------------
interface fbacc_in_if;
  import fbacc_pkg::*;

  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface fbacc_out_if;
  import fbacc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PC_W-1:0]  next_pc;
  logic [NIB_W-1:0] accumulator;
  logic [NIB_W-1:0] out_port;
  logic             branch_taken;
  logic             illegal;

  modport source (
    output valid, output next_pc, output accumulator, output out_port,
    output branch_taken, output illegal, input ready
  );
  modport sink (
    input valid, input next_pc, input accumulator, input out_port,
    input branch_taken, input illegal, output ready
  );
endinterface

### design/fbacc_regfile.sv
// ----------------------------------------------------------------------------
// fbacc_regfile
// Eight 4-bit registers, one write port, one read port, register zero tapped.
// ----------------------------------------------------------------------------
module fbacc_regfile (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [fbacc_pkg::REG_IDX_W-1:0]  wr_idx_i,
  input  logic [fbacc_pkg::NIB_W-1:0]      wr_data_i,
  input  logic [fbacc_pkg::REG_IDX_W-1:0]  rd_idx_i,
  output logic [fbacc_pkg::NIB_W-1:0]      rd_data_o,
  output logic [fbacc_pkg::NIB_W-1:0]      r0_o
);
  import fbacc_pkg::*;

  logic [NIB_W-1:0] regs_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (we_i) begin
      regs_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = regs_q[rd_idx_i];
  assign r0_o      = regs_q[0];

endmodule

### design/fbacc_exec.sv
// ----------------------------------------------------------------------------
// fbacc_exec
// Decode and execute of one instruction: branch, ALU and load/store.
// ----------------------------------------------------------------------------
module fbacc_exec (
  input  logic [fbacc_pkg::INSTR_W-1:0] instr_i,
  input  logic [fbacc_pkg::PC_W-1:0]    pc_i,
  input  logic [fbacc_pkg::NIB_W-1:0]   acc_i,
  input  logic [fbacc_pkg::NIB_W-1:0]   reg_data_i,
  output fbacc_pkg::exec_t              exec_o
);
  import fbacc_pkg::*;

  op_e              op;
  logic [NIB_W-1:0] opnd;
  logic [PC_W-1:0]  pc_inc;

  assign op     = op_e'(instr_i[OP_LSB +: OP_W]);
  assign opnd   = op[IMM_SEL] ? instr_i[NIB_W-1:0] : reg_data_i;
  assign pc_inc = pc_i + PC_W'(1);

  always_comb begin
    exec_o          = '0;
    exec_o.next_pc  = pc_inc;
    exec_o.acc      = acc_i;
    exec_o.reg_idx  = instr_i[REG_IDX_W-1:0];
    exec_o.reg_data = acc_i;

    if (instr_i[BRANCH_POS]) begin
      // Conditional branch on the accumulator sign bit; target is seven bits.
      if (acc_i[SIGN_POS]) begin
        exec_o.next_pc = {1'b0, instr_i[BRANCH_POS-1:0]};
        exec_o.taken   = 1'b1;
      end
    end else begin
      case (op)
        OP_ADD, OP_ADDI:   exec_o.acc = acc_i + opnd;
        OP_NAND, OP_NANDI: exec_o.acc = ~(acc_i & opnd);
        OP_XOR, OP_XORI:   exec_o.acc = acc_i ^ opnd;
        OP_LDST: begin
          if (instr_i[STORE_POS]) begin
            exec_o.reg_we = 1'b1;
          end else begin
            exec_o.acc = reg_data_i;
          end
        end
        default: exec_o.illegal = 1'b1;
      endcase
    end
  end

endmodule

### design/four_bit_accumulator_cpu_step.sv
// ----------------------------------------------------------------------------
// four_bit_accumulator_cpu_step
// One instruction per transfer on a 4-bit accumulator machine.
//
// Each input transfer carries one 8-bit instruction, which this core executes
// against its program counter, accumulator and eight 4-bit registers, then
// hands out one result transfer with the new program counter, the
// accumulator, register zero (the output port) and the branch and illegal
// flags. An instruction is captured in an input register, executed by the
// decode/ALU logic, and its result is written to the output register in the
// same edge that updates the machine state. A new instruction can be taken
// every cycle while the output register is not stalled. Execution is
// stalled only when the output register is full and not being drained; the
// input register then holds one more instruction before ready drops. State
// comes out of reset as zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_bit_accumulator_cpu_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  fbacc_in_if.sink     in_i,
  fbacc_out_if.source  out_o
);
  import fbacc_pkg::*;

  logic               s1_valid_q;
  logic [INSTR_W-1:0] s1_instr_q;
  logic [PC_W-1:0]    pc_q;
  logic [NIB_W-1:0]   acc_q;
  logic               out_valid_q;
  result_t            res_q;
  result_t            res_d;
  exec_t              ex;
  logic               exec_fire;
  logic               in_ready;
  logic [NIB_W-1:0]   rd_data;
  logic [NIB_W-1:0]   r0;

  // The instruction in the input register executes whenever the output
  // register is empty or is handing off its result in this cycle.
  assign exec_fire = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready  = !s1_valid_q || exec_fire;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_instr_q <= in_i.instruction;
    end
  end

  fbacc_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (exec_fire && ex.reg_we),
    .wr_idx_i  (ex.reg_idx),
    .wr_data_i (ex.reg_data),
    .rd_idx_i  (s1_instr_q[REG_IDX_W-1:0]),
    .rd_data_o (rd_data),
    .r0_o      (r0)
  );

  fbacc_exec u_exec (
    .instr_i    (s1_instr_q),
    .pc_i       (pc_q),
    .acc_i      (acc_q),
    .reg_data_i (rd_data),
    .exec_o     (ex)
  );

  // Machine state advances only when an instruction actually executes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      acc_q <= '0;
    end else if (exec_fire) begin
      pc_q  <= ex.next_pc;
      acc_q <= ex.acc;
    end
  end

  // Register zero as it stands after this instruction, including a store to it.
  always_comb begin
    res_d              = '0;
    res_d.next_pc      = ex.next_pc;
    res_d.accumulator  = ex.acc;
    res_d.out_port     = (ex.reg_we && (ex.reg_idx == '0)) ? ex.reg_data : r0;
    res_d.branch_taken = ex.taken;
    res_d.illegal      = ex.illegal;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.next_pc      = res_q.next_pc;
  assign out_o.accumulator  = res_q.accumulator;
  assign out_o.out_port     = res_q.out_port;
  assign out_o.branch_taken = res_q.branch_taken;
  assign out_o.illegal      = res_q.illegal;

  // A taken branch always lands in the lower half and is never flagged illegal.
  `ASSERT_HOLDS(a_branch_target, clk_i, rst_ni,
                !(out_valid_q && res_q.branch_taken) ||
                (!res_q.next_pc[BRANCH_POS] && !res_q.illegal))

  // An illegal opcode leaves the accumulator untouched.
  `ASSERT_NEXT(a_illegal_nop, clk_i, rst_ni, exec_fire && ex.illegal, acc_q == $past(acc_q))

  // While the result is stalled, nothing executes and the state holds.
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_q && !out_o.ready,
               out_valid_q && $stable(pc_q) && $stable(acc_q))

  // Ready only drops while an instruction waits in the input register.
  `ASSERT_HOLDS(a_ready_low, clk_i, rst_ni, in_ready || s1_valid_q)

endmodule
